[design/tmc_pkg.sv]
// Shared types and codes for the thermostat mode controller.
// Request, mode and drive codes, register indexes and the item/result records.
// No dependencies.
package tmc_pkg;

	localparam int REQ_W      = 3;
	localparam int TEMP_W     = 8;
	localparam int MODE_W     = 2;
	localparam int DRV_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_SAMPLE = 3'd0;
	localparam logic [REQ_W-1:0] REQ_UP     = 3'd1;
	localparam logic [REQ_W-1:0] REQ_DOWN   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_POWER  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_TICK   = 3'd4;

	// Operating modes
	localparam logic [MODE_W-1:0] MODE_OFF = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ON  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SET = 2'd2;

	// Element drive
	localparam logic [DRV_W-1:0] DRV_IDLE = 2'd0;
	localparam logic [DRV_W-1:0] DRV_HEAT = 2'd1;
	localparam logic [DRV_W-1:0] DRV_COOL = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SET_MIN     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SET_MAX     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_BAND   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_SET = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 3'd4;

	// Register reset values
	localparam logic [7:0]  SET_MIN_RST   = 8'd35;
	localparam logic [7:0]  SET_MAX_RST   = 8'd75;
	localparam logic [5:0]  STEP_BAND_RST = 6'd5;
	localparam logic [7:0]  DEFAULT_SET   = 8'd60;
	localparam logic [15:0] TIMEOUT_RST   = 16'd5;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [TEMP_W-1:0] temp_sample;
	} item_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode_now;
		logic              heater_on;
		logic              cooler_on;
		logic              led_on;
		logic [7:0]        average_temp;
		logic [7:0]        set_point;
	} result_t;

	// Strobes from the controller to the sample ring memory
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} ring_ctl_t;

endpackage

[design/tmc_if.sv]
// Request and result channel interfaces for the thermostat mode controller.
// Depends on tmc_pkg for field widths.
interface tmc_req_if import tmc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [TEMP_W-1:0] temp_sample;

	modport source(output valid, req_type, temp_sample, input ready);
	modport sink(input valid, req_type, temp_sample, output ready);
endinterface

interface tmc_res_if import tmc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode_now;
	logic              heater_on;
	logic              cooler_on;
	logic              led_on;
	logic [7:0]        average_temp;
	logic [7:0]        set_point;

	modport source(output valid, mode_now, heater_on, cooler_on, led_on, average_temp,
		set_point, input ready);
	modport sink(input valid, mode_now, heater_on, cooler_on, led_on, average_temp,
		set_point, output ready);
endinterface

[design/tmc_ring_mem.sv]
// Sample ring storage: one write port, one registered read port.
// Depends on tmc_pkg for the strobe record.
module tmc_ring_mem import tmc_pkg::*; #(
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  ring_ctl_t                ctl,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [TEMP_W-1:0]        wr_data,
	output logic [TEMP_W-1:0]        rd_data
);

	logic [TEMP_W-1:0] ring_q [DEPTH];
	logic [TEMP_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			ring_q[wr_addr] <= wr_data;
		end
	end

	// Hold the read word until the next read so a stalled consumer keeps it
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_q <= ring_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[design/tmc_ctrl.sv]
// Controller state and per-item update: mode, set point, running sum, drive.
// Depends on tmc_pkg; drives the sample ring memory addresses.
module tmc_ctrl import tmc_pkg::*; #(
	parameter int AVG_DEPTH = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic                         step_en,
	input  item_t                        item,
	input  logic [TEMP_W-1:0]            old_sample,
	output logic                         wr_en,
	output logic [$clog2(AVG_DEPTH)-1:0] wr_addr,
	output logic [$clog2(AVG_DEPTH)-1:0] rd_addr,
	output result_t                      result
);

	localparam int IDX_W = $clog2(AVG_DEPTH);
	localparam int SUM_W = TEMP_W + IDX_W;
	// floor(sum / AVG_DEPTH) = (sum * RECIP) >> SHIFT, exact for sum < 2**SUM_W
	localparam int SHIFT = SUM_W + IDX_W;
	localparam int MUL_W = SHIFT + 1;
	localparam int PROD_W = SUM_W + MUL_W;
	localparam logic [MUL_W-1:0] RECIP = MUL_W'((2 ** SHIFT + AVG_DEPTH - 1) / AVG_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(AVG_DEPTH - 1);

	logic [7:0]        set_min_q, set_max_q;
	logic [5:0]        step_band_q;
	logic [15:0]       timeout_q;

	logic [MODE_W-1:0] mode_q, mode_d;
	logic [IDX_W-1:0]  ring_index_q, idx_next;
	logic              wrapped_q, primed_q;
	logic [TEMP_W-1:0] first_q;
	logic [SUM_W-1:0]  sum_q, sum_d, mul_in;
	logic [7:0]        desired_q, desired_d, saved_q, saved_d;
	logic [15:0]       idle_q, idle_d, idle_inc;
	logic [DRV_W-1:0]  drive_q, drive_d;
	logic              blink_q, blink_d;

	logic              take, advance;
	logic [TEMP_W-1:0] t, old;
	logic [SUM_W-1:0]  sum_upd;
	logic [PROD_W-1:0] prod;
	logic [7:0]        avg_d;
	logic [8:0]        avg_pb, d_pb, up_sum, min_pb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_min_q   <= SET_MIN_RST;
			set_max_q   <= SET_MAX_RST;
			step_band_q <= STEP_BAND_RST;
			timeout_q   <= TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SET_MIN:   set_min_q   <= cfg_data[7:0];
				REG_SET_MAX:   set_max_q   <= cfg_data[7:0];
				REG_STEP_BAND: step_band_q <= cfg_data[5:0];
				REG_TIMEOUT:   timeout_q   <= cfg_data;
				// default_set only matters at reset, where it is the constant
				default: ;
			endcase
		end
	end

	assign t        = item.temp_sample;
	assign take     = (item.req_type == REQ_SAMPLE) && (mode_q == MODE_ON);
	assign advance  = step_en && take && primed_q;
	assign idx_next = (ring_index_q == LAST_IDX) ? '0 : ring_index_q + 1'b1;

	// Slots not yet rewritten since priming still hold the first sample
	assign old     = wrapped_q ? old_sample : first_q;
	assign sum_upd = sum_q - SUM_W'(old) + SUM_W'(t);
	assign mul_in  = (take && primed_q) ? sum_upd : sum_q;
	assign prod    = PROD_W'(mul_in) * PROD_W'(RECIP);
	assign avg_d   = (take && !primed_q) ? t : prod[SHIFT +: 8];

	assign avg_pb   = {1'b0, avg_d} + 9'(step_band_q);
	assign d_pb     = {1'b0, desired_q} + 9'(step_band_q);
	assign up_sum   = d_pb;
	assign min_pb   = {1'b0, set_min_q} + 9'(step_band_q);
	assign idle_inc = (idle_q != 16'hFFFF) ? idle_q + 16'd1 : idle_q;

	always_comb begin
		mode_d    = mode_q;
		sum_d     = sum_q;
		desired_d = desired_q;
		saved_d   = saved_q;
		idle_d    = idle_q;
		drive_d   = drive_q;
		blink_d   = blink_q;
		case (item.req_type)
			REQ_SAMPLE: begin
				if (take) begin
					sum_d = primed_q ? sum_upd : SUM_W'(t) * SUM_W'(AVG_DEPTH);
					if (({1'b0, desired_q} < avg_pb) && (d_pb > {1'b0, avg_d})) begin
						drive_d = DRV_IDLE;
					end else if ({1'b0, desired_q} < avg_pb) begin
						drive_d = DRV_COOL;
					end else begin
						drive_d = DRV_HEAT;
					end
					if (drive_d != DRV_HEAT) begin
						blink_d = 1'b0;
					end
				end
			end
			REQ_UP, REQ_DOWN: begin
				if (mode_q == MODE_ON) begin
					mode_d  = MODE_SET;
					idle_d  = '0;
					drive_d = DRV_IDLE;
					blink_d = 1'b0;
					saved_d = desired_q;
				end else if (mode_q == MODE_SET) begin
					if (item.req_type == REQ_UP) begin
						if (desired_q < set_max_q) begin
							desired_d = (up_sum > {1'b0, set_max_q}) ? set_max_q : up_sum[7:0];
						end
					end else begin
						if (desired_q > set_min_q) begin
							desired_d = ({1'b0, desired_q} >= min_pb) ?
								desired_q - {2'b00, step_band_q} : set_min_q;
						end
					end
					saved_d = desired_d;
					idle_d  = '0;
				end
			end
			REQ_POWER: begin
				if (mode_q == MODE_OFF) begin
					mode_d    = MODE_ON;
					desired_d = saved_q;
				end else begin
					mode_d = MODE_OFF;
				end
				drive_d = DRV_IDLE;
				blink_d = 1'b0;
				idle_d  = '0;
			end
			REQ_TICK: begin
				if (mode_q == MODE_ON) begin
					if (drive_q == DRV_HEAT) begin
						blink_d = ~blink_q;
					end
				end else if (mode_q == MODE_SET) begin
					if (idle_inc >= timeout_q) begin
						mode_d = MODE_ON;
						idle_d = '0;
					end else begin
						idle_d = idle_inc;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_OFF;
			ring_index_q <= '0;
			wrapped_q    <= 1'b0;
			primed_q     <= 1'b0;
			first_q      <= '0;
			sum_q        <= '0;
			desired_q    <= DEFAULT_SET;
			saved_q      <= DEFAULT_SET;
			idle_q       <= '0;
			drive_q      <= DRV_IDLE;
			blink_q      <= 1'b0;
		end else if (step_en) begin
			mode_q    <= mode_d;
			sum_q     <= sum_d;
			desired_q <= desired_d;
			saved_q   <= saved_d;
			idle_q    <= idle_d;
			drive_q   <= drive_d;
			blink_q   <= blink_d;
			if (take && !primed_q) begin
				primed_q <= 1'b1;
				first_q  <= t;
			end
			if (advance) begin
				ring_index_q <= idx_next;
				if (ring_index_q == LAST_IDX) begin
					wrapped_q <= 1'b1;
				end
			end
		end
	end

	assign wr_en   = advance;
	assign wr_addr = ring_index_q;
	// Forward the advanced index so the next item reads the slot it will replace
	assign rd_addr = advance ? idx_next : ring_index_q;

	always_comb begin
		result.mode_now     = mode_d;
		result.heater_on    = (drive_d == DRV_HEAT);
		result.cooler_on    = (drive_d == DRV_COOL);
		result.led_on       = (drive_d == DRV_COOL) || ((drive_d == DRV_HEAT) && blink_d);
		result.average_temp = avg_d;
		result.set_point    = desired_d;
	end

endmodule

[design/thermostat_mode_controller_unit.sv]
// Thermostat mode controller top level: request staging, output register, ring memory.
// Depends on tmc_pkg, tmc_req_if/tmc_res_if, tmc_ring_mem and tmc_ctrl.
//
// Usage: every request on req (sample, up, down, on/off press, tick) yields
// exactly one result on res with the mode, heater/cooler/LED drives, moving
// average and set point after that request. Both channels use valid/ready;
// a request moves when both are high at a rising clock edge.
// Configuration: cfg_we with cfg_index 0..4 (set_min, set_max, step_band, default_set
// (ignored), timeout_ticks) and cfg_data; write only while the block is idle.
// Path: an accepted request is registered in stage 1; its result is then
// registered in the output register, which drives res.
// Throughput: one request per cycle while res is taken; the sample ring memory
// is read as a request enters stage 1, ahead of the update, and the ring index is
// forwarded so back-to-back samples always read the slot they will replace.
// Reset (arst_n low): mode off, set point 60, average 0, drives off, ring empty.
// The first sample in on mode fills the whole ring logically; no clear pass.
// Stall: when res is not taken the result holds in the output register, one
// more request parks in stage 1, then req.ready drops until res moves.
module thermostat_mode_controller_unit import tmc_pkg::*; #(
	parameter int AVG_DEPTH = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	tmc_req_if.sink               req,
	tmc_res_if.source             res
);

	localparam int IDX_W = $clog2(AVG_DEPTH);

	logic              valid_s1;
	item_t             item_s1;
	logic              out_valid_q;
	result_t           out_q;
	logic              fire_s1, accept;
	ring_ctl_t         ring_ctl;
	logic [IDX_W-1:0]  rd_addr, wr_addr;
	logic [TEMP_W-1:0] rd_data;
	logic              wr_en;
	result_t           result;

	// Advance stage 1 when the output register is empty or being drained
	assign fire_s1   = valid_s1 && (!out_valid_q || res.ready);
	assign req.ready = !valid_s1 || fire_s1;
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// Hold the staged request while stalled
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.req_type    <= req.req_type;
			item_s1.temp_sample <= req.temp_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_q <= result;
		end
	end

	// Read the ring as a request enters stage 1; write back as it leaves
	assign ring_ctl.rd_en = accept;
	assign ring_ctl.wr_en = wr_en;

	tmc_ring_mem #(
		.DEPTH(AVG_DEPTH)
	) u_ring (
		.clk    (clk),
		.ctl    (ring_ctl),
		.rd_addr(rd_addr),
		.wr_addr(wr_addr),
		.wr_data(item_s1.temp_sample),
		.rd_data(rd_data)
	);

	tmc_ctrl #(
		.AVG_DEPTH(AVG_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step_en   (fire_s1),
		.item      (item_s1),
		.old_sample(rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr),
		.result    (result)
	);

	assign res.valid        = out_valid_q;
	assign res.mode_now     = out_q.mode_now;
	assign res.heater_on    = out_q.heater_on;
	assign res.cooler_on    = out_q.cooler_on;
	assign res.led_on       = out_q.led_on;
	assign res.average_temp = out_q.average_temp;
	assign res.set_point    = out_q.set_point;

`ifndef SYNTHESIS
	// Heating and cooling are mutually exclusive
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.heater_on && res.cooler_on))
		else $error("heater and cooler both on");

	// Off and setting modes drop every drive and the indicator
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && (res.mode_now == MODE_OFF || res.mode_now == MODE_SET))
		|-> !(res.heater_on || res.cooler_on || res.led_on))
		else $error("drive active outside on mode");

	// A stalled stage 1 must not accept another request
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !res.ready) |-> !req.ready)
		else $error("request accepted over stalled stage");

	// Only stage 1 leaving may write the ring
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> fire_s1)
		else $error("ring written without an update");
`endif

endmodule
